// ===== sv/counter_goodness_task_picker_assert.svh =====
// Assertion macros used by the task picker sequencer.
`ifndef COUNTER_GOODNESS_TASK_PICKER_ASSERT_SVH
`define COUNTER_GOODNESS_TASK_PICKER_ASSERT_SVH

// Check that an antecedent implies a consequent in the same cycle.
`define CGTP_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check that an antecedent implies a consequent in the next cycle.
`define CGTP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/cgtp_pkg.sv =====
// Shared types and constants of the task picker.
package cgtp_pkg;

   localparam int CNT_W = 9;
   localparam logic [CNT_W-1:0] CNT_MAX = 9'd511;

   typedef enum logic {
      OP_WRITE = 1'b0,
      OP_SCHED = 1'b1
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_NO_VALID = 2'd1,
      ST_ALL_ZERO = 2'd2
   } status_type;

   // Broadcast command from the controller to the slot cells.
   typedef struct packed {
      logic load;
      logic reload;
   } cmd_type;

   // Summary of the scan taken from the end of the chain.
   typedef struct packed {
      logic found;
      logic best_zero;
   } scan_type;

endpackage

// ===== sv/cgtp_cell.sv =====
// One slot cell: holds a task slot and passes the running best to its neighbor.
module cgtp_cell #(
   parameter int IDX_W         = 6,
   parameter int PRIORITY_BITS = 8,
   parameter int CELL_INDEX    = 0
) (
   input  logic                       clock,
   input  logic                       reset,
   input  cgtp_pkg::cmd_type          cmd,
   input  logic                       wr_valid,
   input  logic [PRIORITY_BITS-1:0]   wr_priority,
   input  logic [cgtp_pkg::CNT_W-1:0] wr_counter,
   input  logic                       prev_found,
   input  logic [cgtp_pkg::CNT_W-1:0] prev_best,
   input  logic [IDX_W-1:0]           prev_idx,
   output logic                       next_found,
   output logic [cgtp_pkg::CNT_W-1:0] next_best,
   output logic [IDX_W-1:0]           next_idx
);

   localparam int SUM_W = ((PRIORITY_BITS > cgtp_pkg::CNT_W) ?
                           PRIORITY_BITS : cgtp_pkg::CNT_W) + 1;

   logic                       valid_ff;
   logic [PRIORITY_BITS-1:0]   priority_ff;
   logic [cgtp_pkg::CNT_W-1:0] counter_ff;
   logic [cgtp_pkg::CNT_W-1:0] counter_in;
   logic [SUM_W-1:0]           reload_sum;
   logic                       take;
   logic                       found_ff;
   logic [cgtp_pkg::CNT_W-1:0] best_ff;
   logic [IDX_W-1:0]           idx_ff;

   // Reload as half the counter plus priority, saturated.
   always_comb begin
      reload_sum = SUM_W'(counter_ff >> 1) + SUM_W'(priority_ff);
      if (reload_sum > SUM_W'(cgtp_pkg::CNT_MAX)) begin
         counter_in = cgtp_pkg::CNT_MAX;
      end else begin
         counter_in = cgtp_pkg::CNT_W'(reload_sum);
      end
   end

   // Hold the valid mark.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (cmd.load) begin
         valid_ff <= wr_valid;
      end
   end

   // Load or reload the slot payload.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         priority_ff <= wr_priority;
         counter_ff  <= wr_counter;
      end else if (cmd.reload && valid_ff) begin
         counter_ff <= counter_in;
      end
   end

   // Replace the running best when none is found yet or on a strictly larger counter.
   assign take = valid_ff && (!prev_found || (counter_ff > prev_best));

   // Advance the running best one cell per cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else begin
         found_ff <= prev_found || valid_ff;
      end
      best_ff <= take ? counter_ff : prev_best;
      idx_ff  <= take ? IDX_W'(CELL_INDEX) : prev_idx;
   end

   assign next_found = found_ff;
   assign next_best  = best_ff;
   assign next_idx   = idx_ff;

endmodule

// ===== sv/cgtp_ctrl.sv =====
// Sequencer: accepts words, times the scan through the chain and builds results.
`include "counter_goodness_task_picker_assert.svh"

module cgtp_ctrl #(
   parameter int NUM_TASKS = 64,
   parameter int IDX_W     = 6
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_opcode,
   output cgtp_pkg::cmd_type    cmd,
   input  cgtp_pkg::scan_type   scan,
   input  logic [IDX_W-1:0]     scan_idx,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [5:0]           rsp_next_task,
   output logic [1:0]           rsp_status,
   output logic                 rsp_refilled
);

   localparam int WAIT_W = $clog2(NUM_TASKS + 1);
   localparam logic [WAIT_W-1:0] WAIT_LOAD = WAIT_W'(NUM_TASKS);

   typedef enum logic {
      IDLE,
      SCAN
   } state_type;

   state_type         state_ff;
   logic [WAIT_W-1:0] wait_ff;
   logic              refill_ff;
   logic              rsp_valid_ff;
   logic [5:0]        next_task_ff;
   logic [1:0]        status_ff;
   logic              refilled_ff;
   logic              accept;
   logic              scan_done;
   logic              do_reload;

   assign req_ready = (state_ff == IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign scan_done = (state_ff == SCAN) && (wait_ff == '0);
   assign do_reload = scan_done && scan.found && scan.best_zero && !refill_ff;

   assign cmd.load   = accept && (req_opcode == cgtp_pkg::OP_WRITE);
   assign cmd.reload = do_reload;

   // Hold state, scan timer and the result word.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         rsp_valid_ff <= 1'b0;
         refill_ff    <= 1'b0;
         wait_ff      <= '0;
      end else begin
         if (rsp_valid_ff && rsp_ready && !cmd.load) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            IDLE: begin
               if (accept) begin
                  if (req_opcode == cgtp_pkg::OP_WRITE) begin
                     rsp_valid_ff <= 1'b1;
                     next_task_ff <= '0;
                     status_ff    <= cgtp_pkg::ST_OK;
                     refilled_ff  <= 1'b0;
                  end else begin
                     state_ff  <= SCAN;
                     wait_ff   <= WAIT_LOAD;
                     refill_ff <= 1'b0;
                  end
               end
            end
            SCAN: begin
               if (wait_ff != '0) begin
                  wait_ff <= wait_ff - 1'b1;
               end else if (do_reload) begin
                  // Counters change now; let the new values run through the chain.
                  refill_ff <= 1'b1;
                  wait_ff   <= WAIT_LOAD;
               end else begin
                  state_ff     <= IDLE;
                  rsp_valid_ff <= 1'b1;
                  refilled_ff  <= refill_ff && scan.found;
                  if (!scan.found) begin
                     next_task_ff <= '0;
                     status_ff    <= cgtp_pkg::ST_NO_VALID;
                  end else if (scan.best_zero) begin
                     next_task_ff <= '0;
                     status_ff    <= cgtp_pkg::ST_ALL_ZERO;
                  end else begin
                     next_task_ff <= 6'(scan_idx);
                     status_ff    <= cgtp_pkg::ST_OK;
                  end
               end
            end
            default: begin
               state_ff <= IDLE;
            end
         endcase
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_next_task = next_task_ff;
   assign rsp_status    = status_ff;
   assign rsp_refilled  = refilled_ff;

   `CGTP_ASSERT_SAME(a_no_accept_over_result, clock, reset, accept, !rsp_valid_ff || rsp_ready, "word accepted over a held result")
   `CGTP_ASSERT_SAME(a_zero_task_on_fail, clock, reset, rsp_valid_ff && (status_ff != cgtp_pkg::ST_OK), next_task_ff == '0, "next task not zero on failed pick")
   `CGTP_ASSERT_SAME(a_no_refill_when_empty, clock, reset, rsp_valid_ff && (status_ff == cgtp_pkg::ST_NO_VALID), !refilled_ff, "refill reported with no valid task")
   `CGTP_ASSERT_NEXT(a_reload_restarts_scan, clock, reset, do_reload, (state_ff == SCAN) && (wait_ff == WAIT_LOAD) && refill_ff, "reload did not restart the scan")
   `CGTP_ASSERT_SAME(a_scan_never_accepts, clock, reset, state_ff == SCAN, !req_ready, "ready raised during a scan")

endmodule

// ===== sv/counter_goodness_task_picker.sv =====
// Top level of the counter-goodness task picker: slot chain plus sequencer.
//
// Usage: words enter on the req_ channel (valid/ready). A write word
// (opcode 0) loads slot task_index with valid mark, priority and counter; a
// write beyond the table is dropped but still answered. A schedule word
// (opcode 1) picks the valid slot with the largest counter, lowest index on
// a tie, reloading every valid counter as counter/2 + priority when all are
// zero. Each word yields one result word on the rsp_ channel.
// Timing: a write is answered in the cycle after it is accepted. A schedule
// word waits while the running best moves through the row of slot cells one
// cell per cycle to the end of the row, and again after a reload. One word
// is worked on at a time. Reset clears every valid mark at once. Priorities
// are loaded only by writes, counters by writes and reloads. When the
// receiver stalls, the result word holds in the output register and no new
// word is taken until it leaves.
module counter_goodness_task_picker #(
   parameter int NUM_TASKS     = 64,
   parameter int PRIORITY_BITS = 8
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_opcode,
   input  logic [5:0] req_task_index,
   input  logic       req_entry_valid,
   input  logic [7:0] req_entry_priority,
   input  logic [8:0] req_entry_counter,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [5:0] rsp_next_task,
   output logic [1:0] rsp_status,
   output logic       rsp_refilled
);

   localparam int IDX_W = $clog2(NUM_TASKS);

   cgtp_pkg::cmd_type          cmd;
   cgtp_pkg::scan_type         scan;
   logic [PRIORITY_BITS-1:0]   wr_priority;
   logic [NUM_TASKS:0]         link_found;
   logic [cgtp_pkg::CNT_W-1:0] link_best [NUM_TASKS+1];
   logic [IDX_W-1:0]           link_idx  [NUM_TASKS+1];

   assign wr_priority = PRIORITY_BITS'(req_entry_priority);

   // Feed an empty best into the head of the chain.
   assign link_found[0] = 1'b0;
   assign link_best[0]  = '0;
   assign link_idx[0]   = '0;

   // Build the row of slot cells.
   for (genvar i = 0; i < NUM_TASKS; i++) begin : g_cell
      cgtp_pkg::cmd_type cell_cmd;

      assign cell_cmd.load   = cmd.load && (32'(req_task_index) == 32'(i));
      assign cell_cmd.reload = cmd.reload;

      cgtp_cell #(
         .IDX_W         (IDX_W),
         .PRIORITY_BITS (PRIORITY_BITS),
         .CELL_INDEX    (i)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .cmd         (cell_cmd),
         .wr_valid    (req_entry_valid),
         .wr_priority (wr_priority),
         .wr_counter  (req_entry_counter),
         .prev_found  (link_found[i]),
         .prev_best   (link_best[i]),
         .prev_idx    (link_idx[i]),
         .next_found  (link_found[i+1]),
         .next_best   (link_best[i+1]),
         .next_idx    (link_idx[i+1])
      );
   end

   // Summarize the tail of the chain.
   assign scan.found     = link_found[NUM_TASKS];
   assign scan.best_zero = (link_best[NUM_TASKS] == '0);

   cgtp_ctrl #(
      .NUM_TASKS (NUM_TASKS),
      .IDX_W     (IDX_W)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_opcode    (req_opcode),
      .cmd           (cmd),
      .scan          (scan),
      .scan_idx      (link_idx[NUM_TASKS]),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_next_task (rsp_next_task),
      .rsp_status    (rsp_status),
      .rsp_refilled  (rsp_refilled)
   );

endmodule
